// ----- rtl/core/salr_pkg.sv -----
// Shared types and constants for the set-associative cache lookup block.
// No dependencies; compiled first.
package salr_pkg;

    localparam int ADDR_W = 32;
    localparam int CNT_W  = 32;
    localparam int LFSR_W = 16;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // register indexes, taken from paddr[2]
    localparam logic [0:0] REG_POLICY = 1'b0;
    localparam logic [0:0] REG_SEED   = 1'b1;

    localparam logic POLICY_LRU = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // lookup outcome handed from the update logic to the pipeline
    typedef struct packed {
        logic hit;
        logic evicted;
        logic lfsr_step;
    } t_lookup_flags;

endpackage

// ----- rtl/core/salr_if.sv -----
// Request and response channel interfaces (valid/ready plus payload).
// Depends on salr_pkg.
interface salr_req_if import salr_pkg::*;;
    logic              valid;
    logic              ready;
    logic              mode;
    logic [ADDR_W-1:0] block_address;

    modport source (output valid, output mode, output block_address, input ready);
    modport sink   (input valid, input mode, input block_address, output ready);
endinterface

interface salr_rsp_if import salr_pkg::*;;
    logic             valid;
    logic             ready;
    logic             hit;
    logic [1:0]       way;
    logic             evicted;
    logic [CNT_W-1:0] read_access_total;
    logic [CNT_W-1:0] read_miss_total;
    logic [CNT_W-1:0] write_access_total;
    logic [CNT_W-1:0] write_miss_total;

    modport source (
        output valid, output hit, output way, output evicted,
        output read_access_total, output read_miss_total,
        output write_access_total, output write_miss_total,
        input ready
    );
    modport sink (
        input valid, input hit, input way, input evicted,
        input read_access_total, input read_miss_total,
        input write_access_total, input write_miss_total,
        output ready
    );
endinterface

// ----- rtl/core/salr_index.sv -----
// Address split stage: set index = address mod SETS, tag = quotient (full address
// when SETS is not a power of two). Registered valid/ready stage. Depends on salr_pkg.
module salr_index import salr_pkg::*; #(
    parameter int SETS  = 64,
    parameter int IDX_W = 6,
    parameter int TAG_W = 26
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_mode,
    input  logic [ADDR_W-1:0] i_addr,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_mode,
    output logic [IDX_W-1:0]  o_idx,
    output logic [TAG_W-1:0]  o_tag
);

    localparam bit SETS_POW2 = (SETS & (SETS - 1)) == 0;
    localparam int SH        = $clog2(SETS);

    logic [IDX_W-1:0] idx;
    logic [TAG_W-1:0] tag;
    logic             r_valid;
    logic             r_mode;
    logic [IDX_W-1:0] r_idx;
    logic [TAG_W-1:0] r_tag;

    generate
        if (SETS_POW2) begin : g_pow2
            assign idx = IDX_W'(i_addr & ADDR_W'(SETS - 1));
            assign tag = TAG_W'(i_addr >> SH);
        end else begin : g_resid
            localparam int SW = IDX_W + 2;

            // residue of (b * 256^k) mod SETS for every byte value b
            function automatic logic [256*IDX_W-1:0] byte_tbl(input int k);
                int                     w;
                int                     t;
                int                     acc;
                logic [256*IDX_W-1:0]   tbl;
                w = 1;
                for (int j = 0; j < k; j++) begin
                    t = 0;
                    for (int m = 0; m < 256; m++) begin
                        t = t + w;
                        if (t >= SETS) t = t - SETS;
                    end
                    w = t;
                end
                acc = 0;
                tbl = '0;
                for (int b = 0; b < 256; b++) begin
                    tbl[b*IDX_W +: IDX_W] = IDX_W'(acc);
                    acc = acc + w;
                    if (acc >= SETS) acc = acc - SETS;
                end
                return tbl;
            endfunction

            localparam logic [256*IDX_W-1:0] T0 = byte_tbl(0);
            localparam logic [256*IDX_W-1:0] T1 = byte_tbl(1);
            localparam logic [256*IDX_W-1:0] T2 = byte_tbl(2);
            localparam logic [256*IDX_W-1:0] T3 = byte_tbl(3);

            logic [SW-1:0] sum;
            logic [SW-1:0] part;

            // sum < 4*SETS, two conditional subtracts bring it below SETS
            assign sum  = SW'(T0[i_addr[7:0]*IDX_W   +: IDX_W])
                        + SW'(T1[i_addr[15:8]*IDX_W  +: IDX_W])
                        + SW'(T2[i_addr[23:16]*IDX_W +: IDX_W])
                        + SW'(T3[i_addr[31:24]*IDX_W +: IDX_W]);
            assign part = (sum >= SW'(2 * SETS)) ? sum - SW'(2 * SETS) : sum;
            assign idx  = (part >= SW'(SETS)) ? IDX_W'(part - SW'(SETS)) : IDX_W'(part);
            // full address keeps the tag compare exact without a divider
            assign tag  = TAG_W'(i_addr);
        end
    endgenerate

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_mode  = r_mode;
    assign o_idx   = r_idx;
    assign o_tag   = r_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_mode <= i_mode;
            r_idx  <= idx;
            r_tag  <= tag;
        end
    end

endmodule

// ----- rtl/core/salr_update.sv -----
// Set row update: tag compare, victim choice, recency ranks, fill count.
// Pure combinational logic. Depends on salr_pkg.
module salr_update import salr_pkg::*; #(
    parameter int WAYS   = 4,
    parameter int TAG_W  = 26,
    parameter int RANK_W = 2,
    parameter int FILL_W = 3
) (
    input  logic [WAYS-1:0][TAG_W-1:0]  i_tags,
    input  logic [WAYS-1:0][RANK_W-1:0] i_ranks,
    input  logic [FILL_W-1:0]           i_fill,
    input  logic [TAG_W-1:0]            i_tag,
    input  logic                        i_policy,
    input  logic [LFSR_W-1:0]           i_lfsr,
    output t_lookup_flags               o_flags,
    output logic [RANK_W-1:0]           o_way,
    output logic [WAYS-1:0][TAG_W-1:0]  o_tags,
    output logic [WAYS-1:0][RANK_W-1:0] o_ranks,
    output logic [FILL_W-1:0]           o_fill,
    output logic [LFSR_W-1:0]           o_lfsr
);

    localparam bit WAYS_POW2 = (WAYS & (WAYS - 1)) == 0;

    logic [LFSR_W-1:0] lfsr_nx;
    logic [RANK_W-1:0] rnd_way;
    logic [WAYS-1:0]   hit_vec;
    logic [RANK_W-1:0] hit_way;
    logic [RANK_W-1:0] lru_way;
    logic [RANK_W-1:0] way;
    logic [RANK_W-1:0] sel_rank;
    logic              hit;
    logic              full;
    logic              do_mru;

    // x^16+x^14+x^13+x^11+1, shifting right
    assign lfsr_nx = {i_lfsr[0] ^ i_lfsr[2] ^ i_lfsr[3] ^ i_lfsr[5], i_lfsr[LFSR_W-1:1]};

    generate
        if (WAYS_POW2) begin : g_pow2
            assign rnd_way = RANK_W'(lfsr_nx & LFSR_W'(WAYS - 1));
        end else begin : g_resid
            localparam int SW = RANK_W + 2;

            // residue of (n * 16^k) mod WAYS for every nibble value n
            function automatic logic [16*RANK_W-1:0] nib_tbl(input int k);
                int                    w;
                int                    t;
                int                    acc;
                logic [16*RANK_W-1:0]  tbl;
                w = 1;
                for (int j = 0; j < k; j++) begin
                    t = 0;
                    for (int m = 0; m < 16; m++) begin
                        t = t + w;
                        if (t >= WAYS) t = t - WAYS;
                    end
                    w = t;
                end
                acc = 0;
                tbl = '0;
                for (int b = 0; b < 16; b++) begin
                    tbl[b*RANK_W +: RANK_W] = RANK_W'(acc);
                    acc = acc + w;
                    if (acc >= WAYS) acc = acc - WAYS;
                end
                return tbl;
            endfunction

            localparam logic [16*RANK_W-1:0] T0 = nib_tbl(0);
            localparam logic [16*RANK_W-1:0] T1 = nib_tbl(1);
            localparam logic [16*RANK_W-1:0] T2 = nib_tbl(2);
            localparam logic [16*RANK_W-1:0] T3 = nib_tbl(3);

            logic [SW-1:0] sum;
            logic [SW-1:0] part;

            assign sum  = SW'(T0[lfsr_nx[3:0]*RANK_W   +: RANK_W])
                        + SW'(T1[lfsr_nx[7:4]*RANK_W   +: RANK_W])
                        + SW'(T2[lfsr_nx[11:8]*RANK_W  +: RANK_W])
                        + SW'(T3[lfsr_nx[15:12]*RANK_W +: RANK_W]);
            assign part = (sum >= SW'(2 * WAYS)) ? sum - SW'(2 * WAYS) : sum;
            assign rnd_way = (part >= SW'(WAYS)) ? RANK_W'(part - SW'(WAYS)) : RANK_W'(part);
        end
    endgenerate

    always_comb begin
        hit_vec = '0;
        hit_way = '0;
        lru_way = '0;
        // ways below the fill count are exactly the valid ones
        for (int w = 0; w < WAYS; w++) begin
            hit_vec[w] = (FILL_W'(w) < i_fill) && (i_tags[w] == i_tag);
        end
        // lowest matching way wins
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) hit_way = RANK_W'(w);
            if (i_ranks[w] == '0) lru_way = RANK_W'(w);
        end
        hit  = |hit_vec;
        full = (i_fill == FILL_W'(WAYS));

        if (hit) begin
            way = hit_way;
        end else if (!full) begin
            way = RANK_W'(i_fill);
        end else if (i_policy != POLICY_LRU) begin
            way = rnd_way;
        end else begin
            way = lru_way;
        end

        do_mru = hit ? (i_policy == POLICY_LRU) : (!full || (i_policy == POLICY_LRU));

        sel_rank = i_ranks[way];
        o_ranks  = i_ranks;
        if (do_mru) begin
            for (int w = 0; w < WAYS; w++) begin
                if (RANK_W'(w) == way) begin
                    o_ranks[w] = RANK_W'(WAYS - 1);
                end else if (i_ranks[w] > sel_rank) begin
                    o_ranks[w] = i_ranks[w] - 1'b1;
                end
            end
        end

        o_tags = i_tags;
        if (!hit) o_tags[way] = i_tag;

        o_fill = i_fill;
        if (!hit && !full) o_fill = i_fill + 1'b1;

        o_flags.hit       = hit;
        o_flags.evicted   = !hit && full;
        o_flags.lfsr_step = !hit && full && (i_policy != POLICY_LRU);
        o_way             = way;
        o_lfsr            = lfsr_nx;
    end

endmodule

// ----- rtl/core/set_assoc_cache_lookup_replace.sv -----
// A request moves through the index register, lookup stage and output register.
// One request per cycle unless stalled; set row read-modify-write with forwarding.
// The set row memory (one row per set: tags, ranks, fill count) has one read port.
// Reset (sync, active low): control state cleared, then a clearing pass rewrites
// every row in turn; requests are held off during it, config is taken.
module set_assoc_cache_lookup_replace import salr_pkg::*; #(
    parameter int SETS = 64,
    parameter int WAYS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // APB-style configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    // request and response channels
    salr_req_if.sink          i_req,
    salr_rsp_if.source        o_rsp
);

    localparam bit SETS_POW2 = (SETS & (SETS - 1)) == 0;
    localparam int IDX_W     = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int TAG_W     = SETS_POW2 ? ADDR_W - $clog2(SETS) : ADDR_W;
    localparam int RANK_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FILL_W    = $clog2(WAYS + 1);

    // one memory row holds the whole set
    typedef struct packed {
        logic [WAYS-1:0][RANK_W-1:0] ranks;
        logic [FILL_W-1:0]           fill;
        logic [WAYS-1:0][TAG_W-1:0]  tags;
    } t_row;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    // ---------------- configuration ----------------
    logic              cfg_we;
    logic [0:0]        cfg_idx;
    logic              r_policy;
    logic [LFSR_W-1:0] r_seed;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[APB_AW-1:2];
    assign cfg_we  = psel && penable && pwrite && pready;

    always_comb begin
        case (cfg_idx)
            REG_POLICY: prdata = APB_DW'(r_policy);
            REG_SEED:   prdata = APB_DW'(r_seed);
            default:    prdata = '0;
        endcase
    end

    // ---------------- index stage ----------------
    logic             r_clr_busy;
    logic [IDX_W-1:0] r_clr_idx;
    logic             idx_ready;
    logic             a_valid;
    logic             a_mode;
    logic [IDX_W-1:0] a_idx;
    logic [TAG_W-1:0] a_tag;
    logic             issue;

    // requests wait while the clearing pass runs
    assign i_req.ready = idx_ready && !r_clr_busy;

    salr_index #(
        .SETS  (SETS),
        .IDX_W (IDX_W),
        .TAG_W (TAG_W)
    ) u_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid && !r_clr_busy),
        .o_ready (idx_ready),
        .i_mode  (i_req.mode),
        .i_addr  (i_req.block_address),
        .o_valid (a_valid),
        .i_ready (issue),
        .o_mode  (a_mode),
        .o_idx   (a_idx),
        .o_tag   (a_tag)
    );

    // ---------------- row memory ----------------
    t_row             r_mem [SETS];
    t_row             r_rd_row;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    t_row             mem_wdata;
    t_row             clr_row;

    always_comb begin
        clr_row = '0;
        for (int w = 0; w < WAYS; w++) begin
            clr_row.ranks[w] = RANK_W'(w);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (issue) r_rd_row <= r_mem[a_idx];
    end

    // ---------------- lookup / update stage ----------------
    logic              r_s1_valid;
    logic              r_s1_mode;
    logic [IDX_W-1:0]  r_s1_idx;
    logic [TAG_W-1:0]  r_s1_tag;
    logic              r_fwd;
    t_row              r_fwd_row;
    t_row              cur_row;
    t_row              upd_row;
    t_lookup_flags     flags;
    logic [RANK_W-1:0] upd_way;
    logic [LFSR_W-1:0] upd_lfsr;
    logic [LFSR_W-1:0] r_lfsr;
    logic              r_out_valid;
    logic              out_free;
    logic              s1_done;

    assign out_free = !r_out_valid || o_rsp.ready;
    assign s1_done  = r_s1_valid && out_free;
    // a new request reads its row while the previous one is written back
    assign issue    = a_valid && !r_clr_busy && (!r_s1_valid || s1_done);

    // the read issued in the write-back cycle of the same set sees stale data
    assign cur_row  = r_fwd ? r_fwd_row : r_rd_row;

    salr_update #(
        .WAYS   (WAYS),
        .TAG_W  (TAG_W),
        .RANK_W (RANK_W),
        .FILL_W (FILL_W)
    ) u_update (
        .i_tags   (cur_row.tags),
        .i_ranks  (cur_row.ranks),
        .i_fill   (cur_row.fill),
        .i_tag    (r_s1_tag),
        .i_policy (r_policy),
        .i_lfsr   (r_lfsr),
        .o_flags  (flags),
        .o_way    (upd_way),
        .o_tags   (upd_row.tags),
        .o_ranks  (upd_row.ranks),
        .o_fill   (upd_row.fill),
        .o_lfsr   (upd_lfsr)
    );

    assign mem_we    = r_clr_busy || s1_done;
    assign mem_waddr = r_clr_busy ? r_clr_idx : r_s1_idx;
    assign mem_wdata = r_clr_busy ? clr_row : upd_row;

    // ---------------- counters ----------------
    logic [CNT_W-1:0] r_racc, r_rmiss, r_wacc, r_wmiss;
    logic [CNT_W-1:0] n_racc, n_rmiss, n_wacc, n_wmiss;
    logic [LFSR_W-1:0] n_lfsr;

    always_comb begin
        n_racc  = r_racc;
        n_rmiss = r_rmiss;
        n_wacc  = r_wacc;
        n_wmiss = r_wmiss;
        if (s1_done) begin
            if (r_s1_mode == MODE_WRITE) begin
                n_wacc = sat_inc(r_wacc);
                if (!flags.hit) n_wmiss = sat_inc(r_wmiss);
            end else begin
                n_racc = sat_inc(r_racc);
                if (!flags.hit) n_rmiss = sat_inc(r_rmiss);
            end
        end
    end

    // seed write reloads at once; zero seed would lock the LFSR
    always_comb begin
        n_lfsr = r_lfsr;
        if (cfg_we && cfg_idx == REG_SEED) begin
            n_lfsr = (pwdata[LFSR_W-1:0] == '0) ? LFSR_W'(1) : pwdata[LFSR_W-1:0];
        end else if (s1_done && flags.lfsr_step) begin
            n_lfsr = upd_lfsr;
        end
    end

    // ---------------- output register ----------------
    logic              r_out_hit;
    logic [RANK_W-1:0] r_out_way;
    logic              r_out_evicted;
    logic [CNT_W-1:0]  r_out_racc, r_out_rmiss, r_out_wacc, r_out_wmiss;

    assign o_rsp.valid              = r_out_valid;
    assign o_rsp.hit                = r_out_hit;
    assign o_rsp.way                = 2'(r_out_way);
    assign o_rsp.evicted            = r_out_evicted;
    assign o_rsp.read_access_total  = r_out_racc;
    assign o_rsp.read_miss_total    = r_out_rmiss;
    assign o_rsp.write_access_total = r_out_wacc;
    assign o_rsp.write_miss_total   = r_out_wmiss;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_idx   <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
            r_policy    <= POLICY_LRU;
            r_seed      <= LFSR_W'(1);
            r_lfsr      <= LFSR_W'(1);
            r_racc      <= '0;
            r_rmiss     <= '0;
            r_wacc      <= '0;
            r_wmiss     <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == IDX_W'(SETS - 1)) r_clr_busy <= 1'b0;
            end
            if (issue) begin
                r_s1_valid <= 1'b1;
                r_fwd      <= s1_done && (a_idx == r_s1_idx);
            end else if (s1_done) begin
                r_s1_valid <= 1'b0;
                r_fwd      <= 1'b0;
            end
            if (s1_done) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_we && cfg_idx == REG_POLICY) r_policy <= pwdata[0];
            if (cfg_we && cfg_idx == REG_SEED) r_seed <= pwdata[LFSR_W-1:0];
            r_lfsr  <= n_lfsr;
            r_racc  <= n_racc;
            r_rmiss <= n_rmiss;
            r_wacc  <= n_wacc;
            r_wmiss <= n_wmiss;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_mode <= a_mode;
            r_s1_idx  <= a_idx;
            r_s1_tag  <= a_tag;
            r_fwd_row <= upd_row;
        end
        if (s1_done) begin
            r_out_hit     <= flags.hit;
            r_out_way     <= upd_way;
            r_out_evicted <= flags.evicted;
            r_out_racc    <= n_racc;
            r_out_rmiss   <= n_rmiss;
            r_out_wacc    <= n_wacc;
            r_out_wmiss   <= n_wmiss;
        end
    end

    // ---------------- checks ----------------
    a_no_issue_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !issue)
        else $error("request issued during clearing pass");

    a_fwd_needs_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_s1_valid)
        else $error("forward flag set with empty lookup stage");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (cur_row.fill <= FILL_W'(WAYS)))
        else $error("fill count beyond way count");

    a_miss_le_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_rmiss <= r_out_racc) && (r_out_wmiss <= r_out_wacc))
        else $error("miss count exceeds access count");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_hit && r_out_evicted))
        else $error("hit response flagged an eviction");

endmodule
